>>> src/rv32md_pkg.sv
package rv32md_pkg;

   localparam int XLEN = 32;
   localparam int FUNC_W = 3;
   // one divider cell per quotient bit
   localparam int DIV_STAGES = XLEN;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_MUL    = 3'd0,
      FUNC_MULH   = 3'd1,
      FUNC_MULHSU = 3'd2,
      FUNC_MULHU  = 3'd3,
      FUNC_DIV    = 3'd4,
      FUNC_DIVU   = 3'd5,
      FUNC_REM    = 3'd6,
      FUNC_REMU   = 3'd7
   } func_type;

   // control that travels with a transaction down the cell chain
   typedef struct packed {
      logic            valid;
      logic            want_rem;
      logic            neg_q;
      logic            neg_r;
      logic            special;
      logic [XLEN-1:0] special_val;
   } div_ctrl_type;

   // data held by one divider cell
   typedef struct packed {
      logic [XLEN-1:0] rem;
      logic [XLEN-1:0] quo;
      logic [XLEN-1:0] divisor;
   } div_data_type;

endpackage

>>> src/rv32m_multiply_divide_unit_core.sv
// RV32M multiply/divide unit.
// Channels: issue a transaction by raising start with req_func, req_operand_a
// and req_operand_b; it is taken at any clock edge where busy is low. busy is
// tied low: one transaction can be issued every cycle, with no stalls.
// Each transaction gives exactly one result on rsp_result, marked by a
// one-cycle rsp_valid strobe, in issue order.
// Divides pass one prep stage, 32 divider cells and one output stage;
// multiplies are delayed to the same depth so results stay in order.
// Throughput: one transaction per cycle, set by the chain of
// 32 restoring-divide cells, each resolving one quotient bit per cycle.
// The receiver cannot stall, so results are never held.
// Reset: synchronous, active high; clears all valid bits so no results
// are emitted for transactions in flight.
module rv32m_multiply_divide_unit_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_func,
   input  logic [31:0]                   req_operand_a,
   input  logic [31:0]                   req_operand_b,
   output logic                          rsp_valid,
   output logic [31:0]                   rsp_result
);

   localparam int W = rv32md_pkg::XLEN;
   localparam int N = rv32md_pkg::DIV_STAGES;

   rv32md_pkg::func_type     func;
   logic                     accept;
   rv32md_pkg::div_ctrl_type prep_ctrl_in, prep_ctrl_ff;
   rv32md_pkg::div_data_type prep_data_in, prep_data_ff;
   rv32md_pkg::div_ctrl_type chain_ctrl [N+1];
   rv32md_pkg::div_data_type chain_data [N+1];
   logic                     is_signed, is_div;
   logic                     mul_valid;
   logic [W-1:0]             mul_result;
   logic                     rsp_valid_ff;
   logic [W-1:0]             rsp_result_ff, div_res_in, rsp_result_in;

   assign busy   = 1'b0;
   assign accept = start;
   assign func   = rv32md_pkg::func_type'(req_func);
   assign is_div = req_func[2];
   assign is_signed = (func == rv32md_pkg::FUNC_DIV) || (func == rv32md_pkg::FUNC_REM);

   // take magnitudes and flag the special cases
   always_comb begin
      prep_ctrl_in.valid    = accept && is_div;
      prep_ctrl_in.want_rem = req_func[1];
      prep_ctrl_in.neg_q    = is_signed && (req_operand_a[W-1] ^ req_operand_b[W-1]);
      prep_ctrl_in.neg_r    = is_signed && req_operand_a[W-1];
      prep_ctrl_in.special  = 1'b0;
      prep_ctrl_in.special_val = '0;
      if (req_operand_b == '0) begin
         prep_ctrl_in.special     = 1'b1;
         prep_ctrl_in.special_val = req_func[1] ? req_operand_a : '1;
      end else if (is_signed && req_operand_a == {1'b1, {(W-1){1'b0}}}
                   && req_operand_b == '1) begin
         prep_ctrl_in.special     = 1'b1;
         prep_ctrl_in.special_val = req_func[1] ? '0 : {1'b1, {(W-1){1'b0}}};
      end
      prep_data_in.rem = '0;
      prep_data_in.quo = (is_signed && req_operand_a[W-1]) ? W'(0 - req_operand_a)
                                                           : req_operand_a;
      prep_data_in.divisor = (is_signed && req_operand_b[W-1]) ? W'(0 - req_operand_b)
                                                               : req_operand_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ctrl_ff.valid <= 1'b0;
      end else begin
         prep_ctrl_ff.valid <= prep_ctrl_in.valid;
      end
      prep_ctrl_ff.want_rem    <= prep_ctrl_in.want_rem;
      prep_ctrl_ff.neg_q       <= prep_ctrl_in.neg_q;
      prep_ctrl_ff.neg_r       <= prep_ctrl_in.neg_r;
      prep_ctrl_ff.special     <= prep_ctrl_in.special;
      prep_ctrl_ff.special_val <= prep_ctrl_in.special_val;
      prep_data_ff             <= prep_data_in;
   end

   assign chain_ctrl[0] = prep_ctrl_ff;
   assign chain_data[0] = prep_data_ff;

   // one cell per quotient bit
   for (genvar g = 0; g < N; g++) begin : g_cell
      rv32md_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl_in  (chain_ctrl[g]),
         .data_in  (chain_data[g]),
         .ctrl_out (chain_ctrl[g+1]),
         .data_out (chain_data[g+1])
      );
   end

   rv32md_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .valid_in   (accept && !is_div),
      .func_in    (func),
      .a_in       (req_operand_a),
      .b_in       (req_operand_b),
      .valid_out  (mul_valid),
      .result_out (mul_result)
   );

   // fix signs, pick the special value, merge with multiplies
   always_comb begin
      if (chain_ctrl[N].special) begin
         div_res_in = chain_ctrl[N].special_val;
      end else if (chain_ctrl[N].want_rem) begin
         div_res_in = chain_ctrl[N].neg_r ? W'(0 - chain_data[N].rem) : chain_data[N].rem;
      end else begin
         div_res_in = chain_ctrl[N].neg_q ? W'(0 - chain_data[N].quo) : chain_data[N].quo;
      end
      rsp_result_in = chain_ctrl[N].valid ? div_res_in : mul_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain_ctrl[N].valid || mul_valid;
      end
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

>>> src/rv32md_div_cell.sv
module rv32md_div_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  rv32md_pkg::div_ctrl_type   ctrl_in,
   input  rv32md_pkg::div_data_type   data_in,
   output rv32md_pkg::div_ctrl_type   ctrl_out,
   output rv32md_pkg::div_data_type   data_out
);

   rv32md_pkg::div_ctrl_type ctrl_ff;
   rv32md_pkg::div_data_type data_ff, data_in_c;
   logic [rv32md_pkg::XLEN:0] trial;
   logic [rv32md_pkg::XLEN:0] shifted;

   // shift in next dividend bit and try subtracting the divisor
   always_comb begin
      shifted = {data_in.rem, data_in.quo[rv32md_pkg::XLEN-1]};
      trial = shifted - {1'b0, data_in.divisor};
      data_in_c.divisor = data_in.divisor;
      if (!trial[rv32md_pkg::XLEN]) begin
         data_in_c.rem = trial[rv32md_pkg::XLEN-1:0];
         data_in_c.quo = {data_in.quo[rv32md_pkg::XLEN-2:0], 1'b1};
      end else begin
         data_in_c.rem = shifted[rv32md_pkg::XLEN-1:0];
         data_in_c.quo = {data_in.quo[rv32md_pkg::XLEN-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      ctrl_ff.want_rem    <= ctrl_in.want_rem;
      ctrl_ff.neg_q       <= ctrl_in.neg_q;
      ctrl_ff.neg_r       <= ctrl_in.neg_r;
      ctrl_ff.special     <= ctrl_in.special;
      ctrl_ff.special_val <= ctrl_in.special_val;
      data_ff             <= data_in_c;
   end

   assign ctrl_out = ctrl_ff;
   assign data_out = data_ff;

endmodule

>>> src/rv32md_mul.sv
module rv32md_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_in,
   input  rv32md_pkg::func_type          func_in,
   input  logic [rv32md_pkg::XLEN-1:0]   a_in,
   input  logic [rv32md_pkg::XLEN-1:0]   b_in,
   output logic                          valid_out,
   output logic [rv32md_pkg::XLEN-1:0]   result_out
);

   localparam int W = rv32md_pkg::XLEN;

   logic          valid_ff;
   logic          high_ff;
   logic [W:0]    a_ff, b_ff;
   logic [2*W+1:0] prod;
   logic [W-1:0]  res_in;

   // extend operands by one bit (sign or zero per operation), then a single 33x33 signed multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      high_ff <= (func_in != rv32md_pkg::FUNC_MUL);
      a_ff <= {(func_in == rv32md_pkg::FUNC_MULH || func_in == rv32md_pkg::FUNC_MULHSU)
               & a_in[W-1], a_in};
      b_ff <= {(func_in == rv32md_pkg::FUNC_MULH) & b_in[W-1], b_in};
   end

   assign prod = 66'($signed(a_ff) * $signed(b_ff));
   assign res_in = high_ff ? prod[2*W-1:W] : prod[W-1:0];

   // align with the divider chain
   logic [W-1:0] res_pipe_ff [rv32md_pkg::DIV_STAGES];
   logic [rv32md_pkg::DIV_STAGES-1:0] valid_pipe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_pipe_ff <= '0;
      end else begin
         valid_pipe_ff <= {valid_pipe_ff[rv32md_pkg::DIV_STAGES-2:0], valid_ff};
      end
      res_pipe_ff[0] <= res_in;
      for (int i = 1; i < rv32md_pkg::DIV_STAGES; i++) begin
         res_pipe_ff[i] <= res_pipe_ff[i-1];
      end
   end

   assign valid_out  = valid_pipe_ff[rv32md_pkg::DIV_STAGES-1];
   assign result_out = res_pipe_ff[rv32md_pkg::DIV_STAGES-1];

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int PIPE_DEPTH = 34;
   localparam int STALL_LIMIT = 2000;

   // expected destination values in issue order
   class mdu_scoreboard;
      logic [31:0] pending_results[$];
      int error_count = 0;

      function automatic logic [31:0] compute(rv32md_pkg::func_type op, logic [31:0] a,
                                              logic [31:0] b);
         logic [63:0] prod;
         logic [31:0] mag_a, mag_b, q, r;
         logic signed [63:0] sa, sb;
         sa = {{32{a[31]}}, a};
         sb = {{32{b[31]}}, b};
         mag_a = a[31] ? -a : a;
         mag_b = b[31] ? -b : b;
         case (op)
            rv32md_pkg::FUNC_MUL: begin
               prod = {32'd0, a} * {32'd0, b};
               return prod[31:0];
            end
            rv32md_pkg::FUNC_MULH: begin
               prod = sa * sb;
               return prod[63:32];
            end
            rv32md_pkg::FUNC_MULHSU: begin
               prod = sa * $signed({32'd0, b});
               return prod[63:32];
            end
            rv32md_pkg::FUNC_MULHU: begin
               prod = {32'd0, a} * {32'd0, b};
               return prod[63:32];
            end
            rv32md_pkg::FUNC_DIVU: return (b == 0) ? 32'hFFFF_FFFF : a / b;
            rv32md_pkg::FUNC_REMU: return (b == 0) ? a : a % b;
            default: begin
               // signed divide: truncate toward zero, remainder follows dividend
               if (b == 0) return (op == rv32md_pkg::FUNC_REM) ? a : 32'hFFFF_FFFF;
               if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                  return (op == rv32md_pkg::FUNC_REM) ? 32'd0 : 32'h8000_0000;
               q = mag_a / mag_b;
               r = mag_a % mag_b;
               if (op == rv32md_pkg::FUNC_REM) return a[31] ? -r : r;
               return (a[31] ^ b[31]) ? -q : q;
            end
         endcase
      endfunction

      function void note_issue(rv32md_pkg::func_type op, logic [31:0] a, logic [31:0] b);
         pending_results.push_back(compute(op, a, b));
      endfunction

      // print one mismatch line and count it
      task report(string msg);
         $display("mismatch: %s", msg);
         error_count++;
      endtask

      task check_result(logic [31:0] got);
         logic [31:0] want;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         want = pending_results.pop_front();
         if (got !== want) begin
            report($sformatf("result got %h want %h", got, want));
         end
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [2:0] req_func = '0;
   logic [31:0] req_operand_a = '0;
   logic [31:0] req_operand_b = '0;
   logic rsp_valid;
   logic [31:0] rsp_result;

   mdu_scoreboard board = new();
   int stall_cycles = 0;
   int idle_pct = 0;

   rv32m_multiply_divide_unit_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b), .rsp_valid(rsp_valid), .rsp_result(rsp_result)
   );

   always #5 clock = ~clock;

   // check results and note accepted transactions at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_result(rsp_result);
         if (start && !busy)
            board.note_issue(rv32md_pkg::func_type'(req_func), req_operand_a,
                             req_operand_b);
         if ((start && !busy) || rsp_valid) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
      end
   end

   // watchdog on cycles with no accepted transaction and no result
   always @(posedge clock) begin
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // issue one transaction, with a random gap first
   task automatic issue(logic [2:0] op, logic [31:0] a, logic [31:0] b);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_func <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(15);
         5: return -$urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   task automatic run_random(int count);
      for (int i = 0; i < count; i++)
         issue(3'($urandom_range(7)), pick_operand(), pick_operand());
   endtask

   initial begin
      logic [31:0] edge_vals[5];
      edge_vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: every operation on extremes, zero divisor, signed overflow
      for (int op = 0; op < 8; op++) begin
         issue(3'(op), 32'h8000_0000, 32'hFFFF_FFFF);
         issue(3'(op), edge_vals[$urandom_range(4)], 32'd0);
         issue(3'(op), 32'hFFFF_FFFF, edge_vals[$urandom_range(4)]);
      end

      idle_pct = 35;
      run_random(270);

      // hold off until the pipeline drains
      start <= 1'b0;
      @(posedge clock);
      while (board.pending_results.size() != 0) @(posedge clock);

      idle_pct = 45;
      run_random(260);
      idle_pct = 0;
      run_random(270);

      start <= 1'b0;
      @(posedge clock);
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);

      if (board.error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

>>> files.f
src/rv32md_pkg.sv
src/rv32md_div_cell.sv
src/rv32md_mul.sv
src/rv32m_multiply_divide_unit_core.sv
sim/tb_top.sv
